// ----- hw/rtl/matrix4_inverse_top_defines.svh -----
// Assertion macros for the checker file of the 4x4 matrix inverse.
// No dependencies; include by bare file name.
`ifndef MATRIX4_INVERSE_TOP_DEFINES_SVH
`define MATRIX4_INVERSE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define M4INV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define M4INV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/m4inv_pkg.sv -----
// Package of the 4x4 matrix inverse: widths, item types, divider handshake types.
// No dependencies.
package m4inv_pkg;

    localparam int ELEM_W  = 32;                  // element width, Q16.16
    localparam int FRAC_W  = 16;                  // fraction bits
    localparam int LIMB_W  = 32;                  // multiplier limb width
    localparam int NLIMB   = 4;                   // limbs of the wide operand
    localparam int B_W     = LIMB_W * NLIMB;      // wide operand width
    localparam int ACC_W   = 4 * ELEM_W + 8;      // accumulator width
    localparam int PROD_W  = ELEM_W + LIMB_W + 1; // one partial product
    localparam int MAG_W   = 3 * ELEM_W + 1;      // cofactor magnitude
    localparam int DET_W   = 4 * ELEM_W + 2;      // determinant magnitude
    localparam int QB_W    = ELEM_W + 1;          // quotient bits developed
    localparam int NUM_W   = MAG_W + 2 * FRAC_W;  // scaled numerator
    localparam int CNT_W   = $clog2(QB_W + 1);

    // Clip bounds on the quotient magnitude.
    localparam logic [QB_W-1:0] LIM_POS = {2'b00, {(ELEM_W-1){1'b1}}};
    localparam logic [QB_W-1:0] LIM_NEG = {2'b01, {(ELEM_W-1){1'b0}}};

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [DET_W-1:0]        t_det;

    typedef struct packed {
        logic [1:0]               column_index;
        logic signed [ELEM_W-1:0] elem0;
        logic signed [ELEM_W-1:0] elem1;
        logic signed [ELEM_W-1:0] elem2;
        logic signed [ELEM_W-1:0] elem3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               out_column;
        logic signed [ELEM_W-1:0] res0;
        logic signed [ELEM_W-1:0] res1;
        logic signed [ELEM_W-1:0] res2;
        logic signed [ELEM_W-1:0] res3;
        logic                     singular;
        logic                     saturated;
        logic                     last_column;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic singular;
        logic dneg;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              clip;
        logic [ELEM_W-1:0] value;
    } t_div_rsp;

    // Index n of the three rows or columns left after removing index d.
    function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] d);
        return (n < d) ? n : 2'(n + 2'd1);
    endfunction

endpackage

// ----- hw/rtl/m4inv_div.sv -----
// Bit-serial restoring divider: one inverse element = cofactor * 2^32 / det.
// Depends on m4inv_pkg.
module m4inv_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  m4inv_pkg::t_div_req i_req,
    input  m4inv_pkg::t_acc     i_cof,
    input  m4inv_pkg::t_det     i_dabs,
    output m4inv_pkg::t_div_rsp o_rsp
);
    import m4inv_pkg::*;

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_END  = 2'd2;

    logic [1:0]       r_st, n_st;
    logic [DET_W-1:0] r_rem;
    logic [QB_W-1:0]  r_low;
    logic [QB_W-1:0]  r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_ovf;

    logic                    w_cneg;
    t_acc                    w_cabs;
    logic [MAG_W-1:0]        w_mag;
    logic [NUM_W-1:0]        w_num;
    logic [NUM_W-QB_W-1:0]   w_high;
    logic                    w_big;
    logic [DET_W:0]          w_r2;
    logic [DET_W:0]          w_diff;
    logic                    w_ge;
    logic [QB_W-1:0]         w_lim;
    logic                    w_clip;
    logic [QB_W-1:0]         w_magc;
    logic [QB_W-1:0]         w_sval;

    // Scale the cofactor magnitude and split off the part above the quotient.
    assign w_cneg = i_cof[ACC_W-1];
    assign w_cabs = w_cneg ? t_acc'(-i_cof) : i_cof;
    assign w_mag  = w_cabs[MAG_W-1:0];
    assign w_num  = {w_mag, {(2*FRAC_W){1'b0}}};
    assign w_high = w_num[NUM_W-1:QB_W];
    assign w_big  = DET_W'(w_high) >= i_dabs;

    // One restoring step per cycle.
    assign w_r2   = {r_rem, r_low[QB_W-1]};
    assign w_diff = w_r2 - {1'b0, i_dabs};
    assign w_ge   = w_r2 >= {1'b0, i_dabs};

    // Clip and apply the sign.
    assign w_lim  = r_neg ? LIM_NEG : LIM_POS;
    assign w_clip = r_ovf || (r_q > w_lim);
    assign w_magc = w_clip ? w_lim : r_q;
    assign w_sval = r_neg ? QB_W'(-w_magc) : w_magc;

    assign o_rsp.done  = (r_st == DV_END);
    assign o_rsp.clip  = w_clip;
    assign o_rsp.value = w_sval[ELEM_W-1:0];

    // Sequencer.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            DV_IDLE: begin
                if (i_req.start) begin
                    n_st = (i_req.singular || w_big) ? DV_END : DV_RUN;
                end
            end
            DV_RUN: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_st = DV_END;
                end
            end
            DV_END:  n_st = DV_IDLE;
            default: n_st = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= DV_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Divider datapath.
    always_ff @(posedge i_clk) begin
        if (r_st == DV_IDLE && i_req.start) begin
            r_neg <= !i_req.singular && (w_cneg ^ i_req.dneg);
            r_ovf <= !i_req.singular && w_big;
            r_rem <= DET_W'(w_high);
            r_low <= w_num[QB_W-1:0];
            r_q   <= '0;
            r_cnt <= CNT_W'(QB_W);
        end else if (r_st == DV_RUN) begin
            r_rem <= w_ge ? w_diff[DET_W-1:0] : w_r2[DET_W-1:0];
            r_q   <= {r_q[QB_W-2:0], w_ge};
            r_low <= {r_low[QB_W-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

// ----- hw/rtl/matrix4_inverse_top.sv -----
// 4x4 matrix inverse by the adjugate method, Q16.16 in and out, saturated.
// Depends on m4inv_pkg and m4inv_div.
//
// Load the matrix as four column items; the column 3 item starts the
// inversion, and the items for columns 0 to 2 are only stored. The work
// is done by one shared 32x33 multiplier that builds the cofactors: the
// four row 0 cofactors first, each with a determinant term, and then all
// 16 cofactors for the output. A bit-serial divider turns each output
// cofactor into one result element. The input is not ready until the
// last result column has been taken.
// A zero determinant gives all-zero results with singular set.
module matrix4_inverse_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  m4inv_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output m4inv_pkg::t_out_item o_item
);
    import m4inv_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LOADA   = 4'd1;
    localparam logic [3:0] ST_LOADB   = 4'd2;
    localparam logic [3:0] ST_MULT    = 4'd3;
    localparam logic [3:0] ST_DRAIN   = 4'd4;
    localparam logic [3:0] ST_DETFIN  = 4'd5;
    localparam logic [3:0] ST_DIVGO   = 4'd6;
    localparam logic [3:0] ST_DIVWAIT = 4'd7;
    localparam logic [3:0] ST_EMIT    = 4'd8;

    localparam logic [1:0] OP_SUB0 = 2'd0;  // minor, first product
    localparam logic [1:0] OP_SUB1 = 2'd1;  // minor, second product
    localparam logic [1:0] OP_SUB2 = 2'd2;  // element times minor
    localparam logic [1:0] OP_DET  = 2'd3;  // row 0 element times cofactor

    localparam logic PASS_DET = 1'b0;
    localparam logic PASS_OUT = 1'b1;

    localparam logic [1:0] LAST_LIMB = 2'(NLIMB - 1);

    logic [3:0]              r_state;
    logic [ELEM_W-1:0]       r_mat [16];
    logic signed [ELEM_W-1:0] r_opa;
    logic [B_W-1:0]          r_b;
    logic [1:0]              r_l;
    logic signed [PROD_W-1:0] r_prod;
    logic [1:0]              r_pl;
    logic                    r_pv;
    t_acc                    r_minor;
    t_acc                    r_cof;
    t_acc                    r_det;
    logic [1:0]              r_op;
    logic [1:0]              r_j;
    logic [1:0]              r_k;
    logic [1:0]              r_i;
    logic                    r_pass;
    logic                    r_singular;
    logic                    r_dneg;
    t_det                    r_dabs;
    logic [ELEM_W-1:0]       r_res [4];
    logic                    r_sat;

    logic [1:0]  w_rr0, w_rr1, w_rr2;
    logic [1:0]  w_ca, w_cb, w_cj;
    logic [1:0]  w_xr, w_xc, w_yr, w_yc;
    logic [3:0]  w_addr;
    logic [ELEM_W-1:0] w_rd;
    logic [LIMB_W-1:0] w_limb;
    logic signed [LIMB_W:0] w_limbop;
    logic signed [PROD_W-1:0] w_prod;
    t_acc        w_dest;
    logic        w_clr;
    logic        w_sub;
    t_acc        w_base;
    t_acc        w_shift;
    t_acc        w_sum;
    t_acc        w_det_abs;
    logic        w_in_acc;
    t_div_req    w_req;
    t_div_rsp    w_rsp;

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = (r_state == ST_EMIT);
    assign w_in_acc = i_valid && o_ready;

    // Rows and columns of the 3x3 submatrix for cofactor (r_k, r_i).
    assign w_rr0 = skip_idx(2'd0, r_k);
    assign w_rr1 = skip_idx(2'd1, r_k);
    assign w_rr2 = skip_idx(2'd2, r_k);
    assign w_ca  = skip_idx((r_j == 2'd0) ? 2'd1 : 2'd0, r_i);
    assign w_cb  = skip_idx((r_j == 2'd2) ? 2'd1 : 2'd2, r_i);
    assign w_cj  = skip_idx(r_j, r_i);

    // Element addresses of the current operation.
    always_comb begin
        w_xr = w_rr1;
        w_xc = w_ca;
        w_yr = w_rr2;
        w_yc = w_cb;
        unique case (r_op)
            OP_SUB0: begin
                w_xr = w_rr1; w_xc = w_ca; w_yr = w_rr2; w_yc = w_cb;
            end
            OP_SUB1: begin
                w_xr = w_rr1; w_xc = w_cb; w_yr = w_rr2; w_yc = w_ca;
            end
            OP_SUB2: begin
                w_xr = w_rr0; w_xc = w_cj;
            end
            OP_DET: begin
                w_xr = 2'd0; w_xc = r_i;
            end
        endcase
    end

    assign w_addr = (r_state == ST_LOADA) ? {w_xc, w_xr} : {w_yc, w_yr};
    assign w_rd   = r_mat[w_addr];

    // Shared multiplier: element times one limb of the wide operand.
    assign w_limb   = r_b[r_l*LIMB_W +: LIMB_W];
    assign w_limbop = {(r_l == LAST_LIMB) & w_limb[LIMB_W-1], w_limb};
    assign w_prod   = r_opa * w_limbop;

    // Accumulator selection, clear and sign of the current operation.
    always_comb begin
        w_dest = r_minor;
        w_clr  = 1'b0;
        w_sub  = 1'b0;
        unique case (r_op)
            OP_SUB0: begin
                w_dest = r_minor; w_clr = 1'b1; w_sub = 1'b0;
            end
            OP_SUB1: begin
                w_dest = r_minor; w_clr = 1'b0; w_sub = 1'b1;
            end
            OP_SUB2: begin
                w_dest = r_cof;
                w_clr  = (r_j == 2'd0);
                w_sub  = (r_j == 2'd1) ^ r_k[0] ^ r_i[0];
            end
            OP_DET: begin
                w_dest = r_det; w_clr = (r_i == 2'd0); w_sub = 1'b0;
            end
        endcase
    end

    // The one wide adder, fed by the registered partial product.
    assign w_base  = (r_pl == 2'd0 && w_clr) ? '0 : w_dest;
    assign w_shift = ACC_W'(r_prod) << (r_pl * LIMB_W);
    assign w_sum   = w_sub ? t_acc'(w_base - w_shift) : t_acc'(w_base + w_shift);

    assign w_det_abs = r_det[ACC_W-1] ? t_acc'(-r_det) : r_det;

    // Divider hookup.
    assign w_req.start    = (r_state == ST_DIVGO);
    assign w_req.singular = r_singular;
    assign w_req.dneg     = r_dneg;

    m4inv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_cof   (r_cof),
        .i_dabs  (r_dabs),
        .o_rsp   (w_rsp)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pv    <= 1'b0;
            r_l     <= 2'd0;
            r_op    <= OP_SUB0;
            r_j     <= 2'd0;
            r_k     <= 2'd0;
            r_i     <= 2'd0;
            r_pass  <= PASS_DET;
            r_sat   <= 1'b0;
        end else begin
            r_pv <= (r_state == ST_MULT);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && i_item.column_index == 2'd3) begin
                        r_state <= ST_LOADA;
                        r_pass  <= PASS_DET;
                        r_k     <= 2'd0;
                        r_i     <= 2'd0;
                        r_j     <= 2'd0;
                        r_op    <= OP_SUB0;
                    end
                end
                ST_LOADA: r_state <= ST_LOADB;
                ST_LOADB: begin
                    r_l     <= 2'd0;
                    r_state <= ST_MULT;
                end
                ST_MULT: begin
                    r_l <= r_l + 2'd1;
                    if (r_l == LAST_LIMB) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_LOADA;
                    unique case (r_op)
                        OP_SUB0: r_op <= OP_SUB1;
                        OP_SUB1: r_op <= OP_SUB2;
                        OP_SUB2: begin
                            if (r_j != 2'd2) begin
                                r_j  <= r_j + 2'd1;
                                r_op <= OP_SUB0;
                            end else if (r_pass == PASS_DET) begin
                                r_op <= OP_DET;
                            end else begin
                                r_state <= ST_DIVGO;
                            end
                        end
                        OP_DET: begin
                            r_j  <= 2'd0;
                            r_op <= OP_SUB0;
                            if (r_i == 2'd3) begin
                                r_state <= ST_DETFIN;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end
                    endcase
                end
                ST_DETFIN: begin
                    r_pass  <= PASS_OUT;
                    r_k     <= 2'd0;
                    r_i     <= 2'd0;
                    r_j     <= 2'd0;
                    r_op    <= OP_SUB0;
                    r_sat   <= 1'b0;
                    r_state <= ST_LOADA;
                end
                ST_DIVGO: r_state <= ST_DIVWAIT;
                ST_DIVWAIT: begin
                    if (w_rsp.done) begin
                        r_sat <= r_sat | w_rsp.clip;
                        if (r_i == 2'd3) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_j     <= 2'd0;
                            r_op    <= OP_SUB0;
                            r_state <= ST_LOADA;
                        end
                    end
                end
                ST_EMIT: begin
                    if (i_ready) begin
                        r_sat <= 1'b0;
                        if (r_k == 2'd3) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_i     <= 2'd0;
                            r_j     <= 2'd0;
                            r_op    <= OP_SUB0;
                            r_state <= ST_LOADA;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        // Column store write.
        if (w_in_acc) begin
            r_mat[{i_item.column_index, 2'd0}] <= i_item.elem0;
            r_mat[{i_item.column_index, 2'd1}] <= i_item.elem1;
            r_mat[{i_item.column_index, 2'd2}] <= i_item.elem2;
            r_mat[{i_item.column_index, 2'd3}] <= i_item.elem3;
        end
        // Operand loads.
        if (r_state == ST_LOADA) begin
            r_opa <= w_rd;
        end
        if (r_state == ST_LOADB) begin
            case (r_op)
                OP_SUB2: r_b <= r_minor[B_W-1:0];
                OP_DET:  r_b <= r_cof[B_W-1:0];
                default: r_b <= {{(B_W-ELEM_W){w_rd[ELEM_W-1]}}, w_rd};
            endcase
        end
        // Partial product register.
        if (r_state == ST_MULT) begin
            r_prod <= w_prod;
            r_pl   <= r_l;
        end
        // Accumulate.
        if (r_pv) begin
            case (r_op)
                OP_SUB2: r_cof   <= w_sum;
                OP_DET:  r_det   <= w_sum;
                default: r_minor <= w_sum;
            endcase
        end
        // Determinant summary.
        if (r_state == ST_DETFIN) begin
            r_singular <= (r_det == '0);
            r_dneg     <= r_det[ACC_W-1];
            r_dabs     <= w_det_abs[DET_W-1:0];
        end
        // Result element capture.
        if (r_state == ST_DIVWAIT && w_rsp.done) begin
            r_res[r_i] <= w_rsp.value;
        end
    end

    assign o_item.out_column  = r_k;
    assign o_item.res0        = r_res[0];
    assign o_item.res1        = r_res[1];
    assign o_item.res2        = r_res[2];
    assign o_item.res3        = r_res[3];
    assign o_item.singular    = r_singular;
    assign o_item.saturated   = r_sat;
    assign o_item.last_column = (r_k == 2'd3);

endmodule

// ----- hw/rtl/m4inv_chk.sv -----
// Port-level checker for the 4x4 matrix inverse, bound to the top level.
// Depends on m4inv_pkg and matrix4_inverse_top_defines.svh.
`include "matrix4_inverse_top_defines.svh"

module m4inv_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input m4inv_pkg::t_in_item  i_item,
    input logic                 o_valid,
    input logic                 i_ready,
    input m4inv_pkg::t_out_item o_item
);
    import m4inv_pkg::*;

    // A result item that is not taken holds.
    `M4INV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_item), "result item changed while stalled")

    // No new item is taken while results are pending.
    `M4INV_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready, "input ready while a result is pending")

    // Taking the last column returns the block to ready.
    `M4INV_ASSERT_NEXT(a_last_ready, i_clk, i_rst_n, o_valid && i_ready && o_item.last_column, o_ready && !o_valid, "block not ready after last column")

    // A singular matrix gives clean zero results.
    `M4INV_ASSERT_NOW(a_singular_zero, i_clk, i_rst_n, o_valid && o_item.singular, o_item.res0 == '0 && o_item.res1 == '0 && o_item.res2 == '0 && o_item.res3 == '0 && !o_item.saturated, "singular result not zero")

    // The last mark sits on column 3 only.
    `M4INV_ASSERT_NOW(a_last_mark, i_clk, i_rst_n, o_valid, o_item.last_column == (o_item.out_column == 2'd3), "last mark on wrong column")

endmodule

bind matrix4_inverse_top m4inv_chk u_m4inv_chk (.*);
